@@ sv/sgrmp_pkg.sv @@
// Shared types and byte constants for the SGR mouse report parser.
package sgrmp_pkg;

    // Commands that the front end hands to the back end
    typedef enum logic [1:0] {
        CMD_EXIT  = 2'd0,
        CMD_UPPER = 2'd1,
        CMD_LOWER = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        EV_EXIT    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_DRAG    = 2'd2,
        EV_RELEASE = 2'd3
    } t_event;

    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_LT       = 8'h3C;
    localparam logic [7:0] BYTE_SEMI     = 8'h3B;
    localparam logic [7:0] BYTE_UPPER_M  = 8'h4D;
    localparam logic [7:0] BYTE_LOWER_M  = 8'h6D;
    localparam logic [7:0] BYTE_DIGIT_LO = 8'h30;
    localparam logic [7:0] BYTE_DIGIT_HI = 8'h39;
    localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
    localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;

    localparam logic [7:0] BUTTON_LEFT = 8'd0;
    localparam logic [7:0] BUTTON_DRAG = 8'd32;
    localparam logic [7:0] BUTTON_MAX  = 8'hFF;

endpackage

@@ sv/sgrmp_front.sv @@
// Front end: byte classifier, escape sequence tracker and field accumulators.
module sgrmp_front
    import sgrmp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_valid,
    output logic                  o_byte_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_cmd_kind             o_cmd_kind,
    output logic [7:0]            o_cmd_button,
    output logic [COORD_BITS-1:0] o_cmd_x,
    output logic [COORD_BITS-1:0] o_cmd_y
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_CSI,
        PH_SGR,
        PH_SKIP_CSI,
        PH_SKIP_ESC
    } t_phase;

    localparam logic [COORD_BITS+3:0] COORD_MAX_W = {4'b0, {COORD_BITS{1'b1}}};
    localparam logic [11:0]           BUTTON_MAX_W = {4'b0, BUTTON_MAX};

    t_phase                r_phase, n_phase;
    logic [1:0]            r_field, n_field;
    logic [7:0]            r_btn, n_btn;
    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;

    logic                  accept;
    logic                  is_final, is_inter, is_digit;
    logic [3:0]            digit;
    logic [11:0]           btn_next;
    logic [COORD_BITS+3:0] x_next, y_next;
    logic [7:0]            btn_sat;
    logic [COORD_BITS-1:0] x_sat, y_sat;

    assign o_byte_ready = !i_q_full;
    assign accept       = i_byte_valid && o_byte_ready;

    assign is_final = (i_byte >= BYTE_FINAL_LO) && (i_byte <= BYTE_FINAL_HI);
    assign is_inter = (i_byte < BYTE_FINAL_LO) || i_byte[7];
    assign is_digit = (i_byte >= BYTE_DIGIT_LO) && (i_byte <= BYTE_DIGIT_HI);
    assign digit    = i_byte[3:0];

    // acc * 10 + d as (acc << 3) + (acc << 1) + d, then clamp
    always_comb begin
        btn_next = ({4'b0, r_btn} << 3) + ({4'b0, r_btn} << 1) + {8'b0, digit};
        x_next   = ({4'b0, r_x} << 3) + ({4'b0, r_x} << 1)
                 + {{COORD_BITS{1'b0}}, digit};
        y_next   = ({4'b0, r_y} << 3) + ({4'b0, r_y} << 1)
                 + {{COORD_BITS{1'b0}}, digit};
        btn_sat  = (btn_next > BUTTON_MAX_W) ? BUTTON_MAX : btn_next[7:0];
        x_sat    = (x_next > COORD_MAX_W) ? {COORD_BITS{1'b1}} : x_next[COORD_BITS-1:0];
        y_sat    = (y_next > COORD_MAX_W) ? {COORD_BITS{1'b1}} : y_next[COORD_BITS-1:0];
    end

    always_comb begin
        n_phase    = r_phase;
        n_field    = r_field;
        n_btn      = r_btn;
        n_x        = r_x;
        n_y        = r_y;
        o_push     = 1'b0;
        o_cmd_kind = CMD_EXIT;
        if (accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_byte == BYTE_ESC) begin
                        n_phase = PH_ESC;
                    end else begin
                        o_push = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (i_byte == BYTE_LBRACKET) begin
                        n_phase = PH_CSI;
                    end else if (is_inter) begin
                        n_phase = PH_SKIP_ESC;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CSI: begin
                    if (i_byte == BYTE_LT) begin
                        n_phase = PH_SGR;
                        n_field = 2'd0;
                        n_btn   = '0;
                        n_x     = '0;
                        n_y     = '0;
                    end else if (is_final) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_SKIP_CSI;
                    end
                end
                PH_SGR: begin
                    if (is_digit) begin
                        if (r_field == 2'd0) begin
                            n_btn = btn_sat;
                        end else if (r_field == 2'd1) begin
                            n_x = x_sat;
                        end else begin
                            n_y = y_sat;
                        end
                    end else if (i_byte == BYTE_SEMI && r_field < 2'd2) begin
                        n_field = r_field + 2'd1;
                    end else begin
                        // any other byte closes the report
                        n_phase = PH_IDLE;
                        if (i_byte == BYTE_UPPER_M) begin
                            o_push     = 1'b1;
                            o_cmd_kind = CMD_UPPER;
                        end else if (i_byte == BYTE_LOWER_M) begin
                            o_push     = 1'b1;
                            o_cmd_kind = CMD_LOWER;
                        end
                    end
                end
                PH_SKIP_CSI: begin
                    if (is_final) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_SKIP_ESC: begin
                    if (!is_inter) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_button = r_btn;
    assign o_cmd_x      = r_x;
    assign o_cmd_y      = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_field <= 2'd0;
            r_btn   <= '0;
            r_x     <= '0;
            r_y     <= '0;
        end else begin
            r_phase <= n_phase;
            r_field <= n_field;
            r_btn   <= n_btn;
            r_x     <= n_x;
            r_y     <= n_y;
        end
    end

endmodule

@@ sv/sgrmp_queue.sv @@
// Small command queue between the front and back ends.
module sgrmp_queue #(
    parameter int WIDTH = 42
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W:0] DEPTH_C = (PTR_W+1)'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count out of range");

endmodule

@@ sv/sgrmp_back.sv @@
// Back end: drag tracking, delta computation and the output register.
module sgrmp_back
    import sgrmp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_pop,
    input  t_cmd_kind             i_cmd_kind,
    input  logic [7:0]            i_cmd_button,
    input  logic [COORD_BITS-1:0] i_cmd_x,
    input  logic [COORD_BITS-1:0] i_cmd_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_event                o_event,
    output logic [7:0]            o_button,
    output logic [COORD_BITS-1:0] o_pos_x,
    output logic [COORD_BITS-1:0] o_pos_y,
    output logic [COORD_BITS:0]   o_delta_x,
    output logic [COORD_BITS:0]   o_delta_y
);

    logic                  r_drag;
    logic [COORD_BITS-1:0] r_base_x, r_base_y;
    logic                  r_out_valid;
    t_event                r_event;
    logic [7:0]            r_button;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y;
    logic [COORD_BITS:0]   r_delta_x, r_delta_y;

    logic                  hit, set_base, set_drag, clr_drag;
    t_event                ev;
    logic [COORD_BITS:0]   dx, dy;

    assign o_pop = i_q_valid && (!r_out_valid || i_ready);
    assign dx    = {1'b0, i_cmd_x} - {1'b0, r_base_x};
    assign dy    = {1'b0, i_cmd_y} - {1'b0, r_base_y};

    always_comb begin
        hit      = 1'b0;
        set_base = 1'b0;
        set_drag = 1'b0;
        clr_drag = 1'b0;
        ev       = EV_EXIT;
        case (i_cmd_kind)
            CMD_EXIT: begin
                hit = 1'b1;
            end
            CMD_UPPER: begin
                if (i_cmd_button == BUTTON_LEFT) begin
                    hit      = 1'b1;
                    ev       = EV_PRESS;
                    set_base = 1'b1;
                    set_drag = 1'b1;
                end else if (i_cmd_button == BUTTON_DRAG && r_drag) begin
                    hit      = 1'b1;
                    ev       = EV_DRAG;
                    set_base = 1'b1;
                end
            end
            CMD_LOWER: begin
                if (i_cmd_button == BUTTON_LEFT) begin
                    hit      = 1'b1;
                    ev       = EV_RELEASE;
                    clr_drag = 1'b1;
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag      <= 1'b0;
            r_base_x    <= '0;
            r_base_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                // the old result, if any, leaves this cycle
                r_out_valid <= hit;
                if (set_drag) begin
                    r_drag <= 1'b1;
                end
                if (clr_drag) begin
                    r_drag <= 1'b0;
                end
                if (set_base) begin
                    r_base_x <= i_cmd_x;
                    r_base_y <= i_cmd_y;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; exit key reports zeros
    always_ff @(posedge i_clk) begin
        if (o_pop && hit) begin
            r_event   <= ev;
            r_button  <= (ev == EV_EXIT) ? 8'd0 : i_cmd_button;
            r_pos_x   <= (ev == EV_EXIT) ? '0 : i_cmd_x;
            r_pos_y   <= (ev == EV_EXIT) ? '0 : i_cmd_y;
            r_delta_x <= (ev == EV_DRAG) ? dx : '0;
            r_delta_y <= (ev == EV_DRAG) ? dy : '0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_event   = r_event;
    assign o_button  = r_button;
    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;
    assign o_delta_x = r_delta_x;
    assign o_delta_y = r_delta_y;

    a_press_arms_drag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd_kind == CMD_UPPER && i_cmd_button == BUTTON_LEFT) |=> r_drag)
        else $error("press did not arm drag");

    a_drag_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && hit && ev == EV_DRAG) |-> r_drag)
        else $error("drag reported while not dragging");

endmodule

@@ sv/sgr_mouse_escape_parser_unit.sv @@
// Top level of the SGR mouse report parser.
// Usage:
//   Input stream (s_axis): one raw terminal byte per request in tdata[7:0].
//   Output stream (m_axis): one result per exit key, press, drag or release.
//   tuser carries the event code, tdata the button, column, row and deltas.
//   Bytes that only advance the escape sequence parser give no result.
// Timing: a byte that closes a report or is an exit key is written to the
//   queue at its accepting edge, then passes into the output register that
//   drives m_axis tvalid once the back end pops it from the queue.
// Throughput: one byte per cycle while the queue is not full; the front end
//   updates its phase and field accumulators as each byte is accepted, and
//   the back end drains one queued command per cycle unless m_axis is held.
// Reset: synchronous, active low; parser returns to idle, drag state and
//   baseline clear, the queue and output register empty.
// Stall: while m_axis is held the output register keeps its result, the
//   four-entry command queue fills, and s_axis tready falls only when the
//   queue is full; bytes that give no result also wait then.
module sgr_mouse_escape_parser_unit
    import sgrmp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // in_byte
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // button, pos_x, pos_y, delta_x, delta_y, zero fill
    output logic [((4*COORD_BITS+10+7)/8)*8-1:0] o_m_axis_tdata,
    output logic [1:0]            o_m_axis_tuser   // event_res
);

    localparam int PAY_W  = 4*COORD_BITS + 10;
    localparam int DATA_W = ((PAY_W + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - PAY_W;
    localparam int CMD_W  = 2 + 8 + 2*COORD_BITS;

    logic                  push, q_full, q_valid, pop;
    t_cmd_kind             f_kind, b_kind;
    logic [7:0]            f_button, b_button;
    logic [COORD_BITS-1:0] f_x, f_y, b_x, b_y;
    logic [CMD_W-1:0]      q_in, q_out;

    t_event                ev;
    logic [7:0]            out_button;
    logic [COORD_BITS-1:0] out_x, out_y;
    logic [COORD_BITS:0]   out_dx, out_dy;

    sgrmp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_s_axis_tvalid),
        .o_byte_ready (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd_kind   (f_kind),
        .o_cmd_button (f_button),
        .o_cmd_x      (f_x),
        .o_cmd_y      (f_y)
    );

    assign q_in = {f_kind, f_button, f_x, f_y};

    sgrmp_queue #(.WIDTH(CMD_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign b_kind   = t_cmd_kind'(q_out[CMD_W-1 -: 2]);
    assign b_button = q_out[2*COORD_BITS +: 8];
    assign b_x      = q_out[COORD_BITS +: COORD_BITS];
    assign b_y      = q_out[COORD_BITS-1:0];

    sgrmp_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_pop        (pop),
        .i_cmd_kind   (b_kind),
        .i_cmd_button (b_button),
        .i_cmd_x      (b_x),
        .i_cmd_y      (b_y),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_event      (ev),
        .o_button     (out_button),
        .o_pos_x      (out_x),
        .o_pos_y      (out_y),
        .o_delta_x    (out_dx),
        .o_delta_y    (out_dy)
    );

    assign o_m_axis_tuser = ev;
    assign o_m_axis_tdata = {{PAD_W{1'b0}}, out_dy, out_dx, out_y, out_x, out_button};

endmodule
